/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock while out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen while out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg
// shared widths and result type for the component search
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int unsigned NODE_W      = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic               edges_dropped;
    logic [NODE_W-1:0]  component_index;
    logic [NODE_W-1:0]  node_id;
  } scc_res_t;

endpackage

`default_nettype wire

/* rtl/scc_emit.sv */
// ----------------------------------------------------------------------------
// scc_emit
// one-deep hold stage plus output register, tags the final beat with tlast
// ----------------------------------------------------------------------------
`default_nettype none

module scc_emit import scc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic                   flush_i,
  input  wire scc_res_t               res_i,
  output logic                        ready_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // node_id[5:0], component_index[11:6], edges_dropped[12], zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  logic     pend_valid_q;
  scc_res_t pend_q;
  logic     out_valid_q;
  scc_res_t out_q;
  logic     last_q;
  logic     out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign ready_o  = !pend_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_i && ready_o) begin
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end
        pend_valid_q <= 1'b1;
      end else if (flush_i && ready_o && pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      if (pend_valid_q) begin
        out_q  <= pend_q;
        last_q <= 1'b0;
      end
      pend_q <= res_i;
    end else if (flush_i && ready_o && pend_valid_q) begin
      out_q  <= pend_q;
      last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire

/* rtl/strongly_connected_components.sv */
// an edge beat is taken while idle; a run beat takes both walk passes
// each pass scans all E stored edges once for every visited node, and
// every edge test goes through the single edge store read port
// the input is held off for the whole run; results leave through a beat register
// reset: async active low, empties the edge store count, clears flags, node_count 64
// ----------------------------------------------------------------------------
// strongly_connected_components
// edge list loader and two-pass depth-first component search
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module strongly_connected_components import scc_pkg::*; #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CNT_W-1:0]       cfg_wdata_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // from_node[5:0], to_node[11:6], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd[0]
  input  wire logic                   s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // node_id[5:0], component_index[11:6], edges_dropped[12], zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                        m_axis_tlast_o
);

  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NIW = $clog2(MAX_NODES);
  localparam int unsigned SPW = $clog2(MAX_NODES + 1);
  localparam int unsigned STW = NODE_W + ECW;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);
  localparam logic [ECW-1:0]   MAX_E = ECW'(MAX_EDGES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_ROOT = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_TEST = 4'd4;
  localparam logic [3:0] S_POPW = 4'd5;
  localparam logic [3:0] S_P2   = 4'd6;
  localparam logic [3:0] S_P2W  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]            state_q;
  logic [CNT_W-1:0]      node_count_q;
  logic [ECW-1:0]        edge_total_q;
  logic                  overflow_q;
  logic [MAX_NODES-1:0]  visited_q;
  logic [NODE_W-1:0]     comp_q;
  logic [CNT_W-1:0]      i_q;
  logic [SPW-1:0]        fin_q;
  logic [SPW-1:0]        j_q;
  logic [SPW-1:0]        sp_q;
  logic [NODE_W-1:0]     root_q;
  logic                  rev_q;
  logic [NODE_W-1:0]     top_u_q;
  logic [ECW-1:0]        top_p_q;

  logic [2*NODE_W-1:0]   edge_mem_q [MAX_EDGES];
  logic [STW-1:0]        stk_mem_q  [MAX_NODES];
  logic [NODE_W-1:0]     fin_mem_q  [MAX_NODES];
  logic [2*NODE_W-1:0]   edge_rd_q;
  logic [STW-1:0]        stk_rd_q;
  logic [NODE_W-1:0]     fin_rd_q;

  logic [CNT_W-1:0]      n_w;
  logic                  in_acc;
  logic [NODE_W-1:0]     in_from;
  logic [NODE_W-1:0]     in_to;
  logic [NODE_W-1:0]     e_src;
  logic [NODE_W-1:0]     e_dst;
  logic                  hit;
  logic                  emit_rdy;
  logic                  push;
  scc_res_t              res;
  logic [NIW-1:0]        stk_raddr;
  logic [NIW-1:0]        fin_raddr;

  assign n_w       = (node_count_q > MAX_N) ? MAX_N : node_count_q;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_from   = s_axis_tdata_i[NODE_W-1:0];
  assign in_to     = s_axis_tdata_i[2*NODE_W-1:NODE_W];
  assign s_axis_tready_o = (state_q == S_IDLE);

  // reversed pass swaps the edge ends
  assign e_src = rev_q ? edge_rd_q[NODE_W-1:0] : edge_rd_q[2*NODE_W-1:NODE_W];
  assign e_dst = rev_q ? edge_rd_q[2*NODE_W-1:NODE_W] : edge_rd_q[NODE_W-1:0];
  assign hit = (e_src == top_u_q) && (CNT_W'(e_src) < n_w) && (CNT_W'(e_dst) < n_w)
               && !visited_q[e_dst[NIW-1:0]];

  assign stk_raddr = NIW'(sp_q - SPW'(2));
  assign fin_raddr = NIW'(j_q - SPW'(1));

  always_comb begin
    push = 1'b0;
    res.node_id         = root_q;
    res.component_index = comp_q;
    res.edges_dropped   = overflow_q;
    if (state_q == S_ROOT) begin
      push = rev_q;
    end else if (state_q == S_TEST) begin
      push = rev_q && hit;
      res.node_id = e_dst;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_rd_q <= edge_mem_q[top_p_q[EIW-1:0]];
    stk_rd_q  <= stk_mem_q[stk_raddr];
    fin_rd_q  <= fin_mem_q[fin_raddr];
    if (in_acc && !s_axis_tuser_i && (edge_total_q < MAX_E)) begin
      edge_mem_q[edge_total_q[EIW-1:0]] <= {in_from, in_to};
    end
    if (state_q == S_TEST && hit && !(rev_q && !emit_rdy)) begin
      stk_mem_q[NIW'(sp_q - SPW'(1))] <= {top_u_q, top_p_q + ECW'(1)};
    end
    if (state_q == S_SCAN && !(top_p_q < edge_total_q) && !rev_q) begin
      fin_mem_q[fin_q[NIW-1:0]] <= top_u_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= MAX_N;
      edge_total_q <= '0;
      overflow_q   <= 1'b0;
      visited_q    <= '0;
      comp_q       <= '0;
      i_q          <= '0;
      fin_q        <= '0;
      j_q          <= '0;
      sp_q         <= '0;
      root_q       <= '0;
      rev_q        <= 1'b0;
      top_u_q      <= '0;
      top_p_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser_i) begin
              visited_q <= '0;
              fin_q     <= '0;
              i_q       <= '0;
              rev_q     <= 1'b0;
              state_q   <= S_P1;
            end else if (edge_total_q < MAX_E) begin
              edge_total_q <= edge_total_q + ECW'(1);
            end else begin
              overflow_q <= 1'b1;
            end
          end
        end
        S_P1: begin
          if (!(i_q < n_w)) begin
            visited_q <= '0;
            comp_q    <= '0;
            j_q       <= fin_q;
            rev_q     <= 1'b1;
            state_q   <= S_P2;
          end else if (visited_q[i_q[NIW-1:0]]) begin
            i_q <= i_q + CNT_W'(1);
          end else begin
            root_q  <= NODE_W'(i_q);
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!rev_q || emit_rdy) begin
            visited_q[root_q[NIW-1:0]] <= 1'b1;
            top_u_q <= root_q;
            top_p_q <= '0;
            sp_q    <= SPW'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (top_p_q < edge_total_q) begin
            state_q <= S_TEST;
          end else begin
            if (!rev_q) begin
              fin_q <= fin_q + SPW'(1);
            end
            if (sp_q == SPW'(1)) begin
              sp_q <= '0;
              if (rev_q) begin
                comp_q  <= comp_q + NODE_W'(1);
                state_q <= S_P2;
              end else begin
                i_q     <= i_q + CNT_W'(1);
                state_q <= S_P1;
              end
            end else begin
              sp_q    <= sp_q - SPW'(1);
              state_q <= S_POPW;
            end
          end
        end
        S_TEST: begin
          if (!hit) begin
            top_p_q <= top_p_q + ECW'(1);
            state_q <= S_SCAN;
          end else if (!rev_q || emit_rdy) begin
            visited_q[e_dst[NIW-1:0]] <= 1'b1;
            top_u_q <= e_dst;
            top_p_q <= '0;
            sp_q    <= sp_q + SPW'(1);
            state_q <= S_SCAN;
          end
        end
        S_POPW: begin
          top_u_q <= stk_rd_q[STW-1:ECW];
          top_p_q <= stk_rd_q[ECW-1:0];
          state_q <= S_SCAN;
        end
        S_P2: begin
          if (j_q == '0) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_P2W;
          end
        end
        S_P2W: begin
          j_q <= j_q - SPW'(1);
          if ((CNT_W'(fin_rd_q) < n_w) && !visited_q[fin_rd_q[NIW-1:0]]) begin
            root_q  <= fin_rd_q;
            state_q <= S_ROOT;
          end else begin
            state_q <= S_P2;
          end
        end
        S_FIN: begin
          if (emit_rdy) begin
            edge_total_q <= '0;
            overflow_q   <= 1'b0;
            comp_q       <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  scc_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .flush_i         (state_q == S_FIN),
    .res_i           (res),
    .ready_o         (emit_rdy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `ASSERT_NEVER(a_edge_total_cap, clk_i, rst_ni, edge_total_q > MAX_E, "edge count past capacity")
  `ASSERT_NEVER(a_stack_depth, clk_i, rst_ni, sp_q > SPW'(MAX_NODES), "walk stack too deep")
  `ASSERT_ALWAYS(a_run_blocks_input, clk_i, rst_ni,
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> !s_axis_tready_o,
    "input not held off after run beat")

endmodule

`default_nettype wire
